[rtl/r2q_pkg.sv]
// ----------------------------------------------------------------------------
// r2q_pkg
// Shared widths, codes and types for the rotation matrix to quaternion block.
// ----------------------------------------------------------------------------
package r2q_pkg;

   localparam int IN_W    = 16;
   localparam int W_W     = 15;
   localparam int XYZ_W   = 16;

   localparam int Q_DEPTH = 4;
   localparam int Q_PTR_W = 2;
   localparam int Q_CNT_W = 3;

   localparam int COMP_W  = 0;
   localparam int COMP_X  = 1;
   localparam int COMP_Y  = 2;
   localparam int COMP_Z  = 3;
   localparam int N_COMP  = 4;

   typedef struct packed {
      logic x_neg;
      logic y_neg;
      logic z_neg;
   } r2q_sign_type;

   typedef struct packed {
      logic almost_full;
      logic has_data;
   } r2q_qstat_type;

endpackage

[rtl/r2q_front.sv]
// ----------------------------------------------------------------------------
// r2q_front
// Accepts a matrix, forms the four clamped diagonal sums as root radicands
// and the three off-diagonal sign flags.
// ----------------------------------------------------------------------------
module r2q_front import r2q_pkg::*; #(
   parameter int FRAC_BITS = 14,
   parameter int SUM_W     = 19,
   parameter int RAD_W     = 30
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic                           busy,
   input  logic signed [IN_W-1:0]         req_e00,
   input  logic signed [IN_W-1:0]         req_e01,
   input  logic signed [IN_W-1:0]         req_e02,
   input  logic signed [IN_W-1:0]         req_e10,
   input  logic signed [IN_W-1:0]         req_e11,
   input  logic signed [IN_W-1:0]         req_e12,
   input  logic signed [IN_W-1:0]         req_e20,
   input  logic signed [IN_W-1:0]         req_e21,
   input  logic signed [IN_W-1:0]         req_e22,
   output logic                           out_valid,
   output logic [N_COMP-1:0][RAD_W-1:0]   out_rad,
   output r2q_sign_type                   out_sign
);

   localparam logic signed [SUM_W-1:0] ONE = SUM_W'(1) << FRAC_BITS;

   logic                         accept;
   logic signed [SUM_W-1:0]      d00, d11, d22;
   logic signed [SUM_W-1:0]      sum [N_COMP];
   logic signed [IN_W:0]         dif_x, dif_y, dif_z;
   logic                         valid_ff;
   logic [N_COMP-1:0][RAD_W-1:0] rad_ff, rad_in;
   r2q_sign_type                 sign_ff, sign_in;

   assign accept = start && !busy;

   assign d00 = SUM_W'(req_e00);
   assign d11 = SUM_W'(req_e11);
   assign d22 = SUM_W'(req_e22);

   assign sum[COMP_W] = ONE + d00 + d11 + d22;
   assign sum[COMP_X] = ONE + d00 - d11 - d22;
   assign sum[COMP_Y] = ONE - d00 + d11 - d22;
   assign sum[COMP_Z] = ONE - d00 - d11 + d22;

   always_comb begin
      for (int j = 0; j < N_COMP; j++) begin
         if (!sum[j][SUM_W-1] && (|sum[j])) begin
            rad_in[j] = RAD_W'(sum[j][SUM_W-2:0]) << (FRAC_BITS - 2);
         end else begin
            rad_in[j] = '0;
         end
      end
   end

   assign dif_x = (IN_W+1)'(req_e21) - (IN_W+1)'(req_e12);
   assign dif_y = (IN_W+1)'(req_e02) - (IN_W+1)'(req_e20);
   assign dif_z = (IN_W+1)'(req_e10) - (IN_W+1)'(req_e01);

   assign sign_in.x_neg = dif_x[IN_W];
   assign sign_in.y_neg = dif_y[IN_W];
   assign sign_in.z_neg = dif_z[IN_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rad_ff  <= rad_in;
         sign_ff <= sign_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_rad   = rad_ff;
   assign out_sign  = sign_ff;

endmodule

[rtl/r2q_queue.sv]
// ----------------------------------------------------------------------------
// r2q_queue
// Short FIFO between front and back; drains one beat per cycle when non-empty.
// ----------------------------------------------------------------------------
module r2q_queue import r2q_pkg::*; #(
   parameter int DATA_W = 123
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   output logic              pop,
   output logic [DATA_W-1:0] pop_data,
   output r2q_qstat_type     stat
);

   logic [DATA_W-1:0]  mem_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0] cnt_ff, cnt_in;

   assign pop = (cnt_ff != '0);

   assign wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
   assign rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (!push && pop) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data         = mem_ff[rd_ptr_ff];
   assign stat.has_data    = pop;
   // one slot held back for the beat in the front register
   assign stat.almost_full = (cnt_ff >= Q_CNT_W'(Q_DEPTH - 1));

   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      !(push && !pop && (cnt_ff == Q_CNT_W'(Q_DEPTH))))
      else $error("queue overflow");

   a_cnt_bound : assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= Q_CNT_W'(Q_DEPTH))
      else $error("queue count out of range");

   a_ptr_gap : assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == '0) || (cnt_ff == Q_CNT_W'(Q_DEPTH)) || (wr_ptr_ff != rd_ptr_ff))
      else $error("queue pointers disagree with count");

endmodule

[rtl/r2q_root.sv]
// ----------------------------------------------------------------------------
// r2q_root
// Pipelined integer square root, one result bit per stage, floor result.
// ----------------------------------------------------------------------------
module r2q_root #(
   parameter int RAD_W = 30
) (
   input  logic                 clock,
   input  logic [RAD_W-1:0]     rad,
   output logic [RAD_W/2-1:0]   root
);

   localparam int NB = RAD_W / 2;
   localparam int RW = NB + 2;

   logic [RW-1:0]    rem_ff  [NB-1];
   logic [NB-1:0]    root_ff [NB];
   logic [RAD_W-1:0] rad_ff  [NB-1];

   for (genvar k = 0; k < NB; k++) begin : g_stage
      logic [RW-1:0]    rem_prev;
      logic [NB-1:0]    root_prev;
      logic [RAD_W-1:0] rad_prev;
      logic [RW-1:0]    cur;
      logic [RW-1:0]    trial;
      logic             ge;
      logic [NB-1:0]    root_in;

      if (k == 0) begin : g_first
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign rad_prev  = rad;
      end else begin : g_next
         assign rem_prev  = rem_ff[k-1];
         assign root_prev = root_ff[k-1];
         assign rad_prev  = rad_ff[k-1];
      end

      assign cur     = {rem_prev[RW-3:0], rad_prev[RAD_W-1 -: 2]};
      assign trial   = {root_prev, 2'b01};
      assign ge      = (cur >= trial);
      assign root_in = {root_prev[NB-2:0], ge};

      always_ff @(posedge clock) begin
         root_ff[k] <= root_in;
      end

      if (k < NB - 1) begin : g_carry
         logic [RW-1:0]    rem_in;
         logic [RAD_W-1:0] rad_in;

         assign rem_in = ge ? cur - trial : cur;
         assign rad_in = rad_prev << 2;

         always_ff @(posedge clock) begin
            rem_ff[k] <= rem_in;
            rad_ff[k] <= rad_in;
         end
      end
   end

   assign root = root_ff[NB-1];

endmodule

[rtl/r2q_back.sv]
// ----------------------------------------------------------------------------
// r2q_back
// Four root pipelines, saturation at one, sign application, result register.
// ----------------------------------------------------------------------------
module r2q_back import r2q_pkg::*; #(
   parameter int FRAC_BITS = 14,
   parameter int RAD_W     = 30
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic [N_COMP-1:0][RAD_W-1:0]  in_rad,
   input  r2q_sign_type                  in_sign,
   output logic                          rsp_valid,
   output logic [W_W-1:0]                rsp_q_w,
   output logic signed [XYZ_W-1:0]       rsp_q_x,
   output logic signed [XYZ_W-1:0]       rsp_q_y,
   output logic signed [XYZ_W-1:0]       rsp_q_z
);

   localparam int NB = RAD_W / 2;
   localparam int CW = (NB > FRAC_BITS + 1) ? NB : FRAC_BITS + 1;
   localparam logic [CW-1:0] ONE = CW'(1) << FRAC_BITS;

   logic [NB-1:0]            root [N_COMP];
   logic [CW-1:0]            mag  [N_COMP];
   logic [XYZ_W-1:0]         low  [N_COMP];
   logic [NB-1:0]            vld_ff;
   r2q_sign_type             sgn_ff [NB];
   r2q_sign_type             sgn_out;

   logic                     rsp_valid_ff;
   logic [W_W-1:0]           q_w_ff, q_w_in;
   logic [XYZ_W-1:0]         q_x_ff, q_x_in;
   logic [XYZ_W-1:0]         q_y_ff, q_y_in;
   logic [XYZ_W-1:0]         q_z_ff, q_z_in;

   for (genvar j = 0; j < N_COMP; j++) begin : g_comp
      logic [CW+XYZ_W-1:0] ext;

      r2q_root #(
         .RAD_W (RAD_W)
      ) u_root (
         .clock (clock),
         .rad   (in_rad[j]),
         .root  (root[j])
      );

      assign mag[j] = (CW'(root[j]) > ONE) ? ONE : CW'(root[j]);
      assign ext    = {{XYZ_W{1'b0}}, mag[j]};
      assign low[j] = ext[XYZ_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[NB-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      sgn_ff[0] <= in_sign;
      for (int k = 1; k < NB; k++) begin
         sgn_ff[k] <= sgn_ff[k-1];
      end
   end

   assign sgn_out = sgn_ff[NB-1];

   assign q_w_in = low[COMP_W][W_W-1:0];
   assign q_x_in = sgn_out.x_neg ? -low[COMP_X] : low[COMP_X];
   assign q_y_in = sgn_out.y_neg ? -low[COMP_Y] : low[COMP_Y];
   assign q_z_in = sgn_out.z_neg ? -low[COMP_Z] : low[COMP_Z];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= vld_ff[NB-1];
      end
   end

   always_ff @(posedge clock) begin
      q_w_ff <= q_w_in;
      q_x_ff <= q_x_in;
      q_y_ff <= q_y_in;
      q_z_ff <= q_z_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_q_w   = q_w_ff;
   assign rsp_q_x   = q_x_ff;
   assign rsp_q_y   = q_y_ff;
   assign rsp_q_z   = q_z_ff;

   a_latency : assert property (@(posedge clock) disable iff (reset)
      in_valid |-> ##(NB+1) rsp_valid_ff)
      else $error("result strobe missing after root latency");

   a_no_stray : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(in_valid, NB+1))
      else $error("result strobe without a matching beat");

   a_mag_sat : assert property (@(posedge clock) disable iff (reset)
      vld_ff[NB-1] |-> (mag[COMP_W] <= ONE))
      else $error("magnitude above one");

endmodule

[rtl/rotation_matrix_to_quaternion_top.sv]
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_top
// Rotation matrix in Q1.FRAC_BITS to unit quaternion, copysign form.
// Path: front register, queue, NB root stages, result register, with NB =
//   ceil((max(FRAC_BITS,17) + FRAC_BITS - 1) / 2), the root stage count; 15 at 14.
// Throughput: one matrix per cycle; the back end drains a beat every cycle,
//   so the queue never holds more than one and busy stays low.
// Reset: synchronous, clears valid state and the queue; no result is lost
//   to stalling since the receiver takes every beat.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_top import r2q_pkg::*; #(
   parameter int FRAC_BITS = 14
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic signed [IN_W-1:0]   req_e00,
   input  logic signed [IN_W-1:0]   req_e01,
   input  logic signed [IN_W-1:0]   req_e02,
   input  logic signed [IN_W-1:0]   req_e10,
   input  logic signed [IN_W-1:0]   req_e11,
   input  logic signed [IN_W-1:0]   req_e12,
   input  logic signed [IN_W-1:0]   req_e20,
   input  logic signed [IN_W-1:0]   req_e21,
   input  logic signed [IN_W-1:0]   req_e22,
   output logic                     rsp_valid,
   output logic [W_W-1:0]           rsp_q_w,
   output logic signed [XYZ_W-1:0]  rsp_q_x,
   output logic signed [XYZ_W-1:0]  rsp_q_y,
   output logic signed [XYZ_W-1:0]  rsp_q_z
);

   localparam int SUM_W  = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 2;
   localparam int RAD_W0 = SUM_W - 1 + FRAC_BITS - 2;
   localparam int RAD_W  = RAD_W0 + (RAD_W0 % 2);
   localparam int DATA_W = N_COMP * RAD_W + $bits(r2q_sign_type);

   logic                         front_valid;
   logic [N_COMP-1:0][RAD_W-1:0] front_rad;
   r2q_sign_type                 front_sign;
   logic                         q_pop;
   logic [DATA_W-1:0]            q_data;
   r2q_qstat_type                q_stat;
   logic [N_COMP-1:0][RAD_W-1:0] back_rad;
   r2q_sign_type                 back_sign;

   assign busy = q_stat.almost_full;

   r2q_front #(
      .FRAC_BITS (FRAC_BITS),
      .SUM_W     (SUM_W),
      .RAD_W     (RAD_W)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_e00   (req_e00),
      .req_e01   (req_e01),
      .req_e02   (req_e02),
      .req_e10   (req_e10),
      .req_e11   (req_e11),
      .req_e12   (req_e12),
      .req_e20   (req_e20),
      .req_e21   (req_e21),
      .req_e22   (req_e22),
      .out_valid (front_valid),
      .out_rad   (front_rad),
      .out_sign  (front_sign)
   );

   r2q_queue #(
      .DATA_W (DATA_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_valid),
      .push_data ({front_sign, front_rad}),
      .pop       (q_pop),
      .pop_data  (q_data),
      .stat      (q_stat)
   );

   assign back_rad  = q_data[N_COMP*RAD_W-1:0];
   assign back_sign = q_data[DATA_W-1 -: $bits(r2q_sign_type)];

   r2q_back #(
      .FRAC_BITS (FRAC_BITS),
      .RAD_W     (RAD_W)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_pop),
      .in_rad    (back_rad),
      .in_sign   (back_sign),
      .rsp_valid (rsp_valid),
      .rsp_q_w   (rsp_q_w),
      .rsp_q_x   (rsp_q_x),
      .rsp_q_y   (rsp_q_y),
      .rsp_q_z   (rsp_q_z)
   );

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Checks rotation_matrix_to_quaternion_top against its own integer predictor.
// A short table of hand-picked matrices comes first: identity, zero, the rail
// values, half turns, sign flips and ties. Random matrices follow, mostly
// true rotations built from random quaternions, in phases with differing
// gaps between beats. Every result beat is compared with the oldest
// outstanding expectation.
// ----------------------------------------------------------------------------
module tb import r2q_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAC_BITS   = 14;
   localparam int UNIT        = 1 << FRAC_BITS;
   localparam int DRAIN_WAIT  = 40;
   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASE_BEATS = 358;

   typedef struct packed {
      logic signed [IN_W-1:0] e00, e01, e02;
      logic signed [IN_W-1:0] e10, e11, e12;
      logic signed [IN_W-1:0] e20, e21, e22;
   } matrix_type;

   typedef struct packed {
      logic [W_W-1:0]          w;
      logic signed [XYZ_W-1:0] x, y, z;
   } quat_type;

   typedef struct {
      matrix_type mat;
      bit         fixed;
      quat_type   quat;
   } stim_row_type;

   logic       clock;
   logic       reset;
   logic       start;
   logic       busy;
   matrix_type req_mat;
   logic       rsp_valid;
   quat_type   rsp_quat;

   quat_type     quat_pending [$];
   stim_row_type stim_table [$];
   int           mismatch_count = 0;
   int           cycle_count = 0;
   int           idle_pct = 0;

   rotation_matrix_to_quaternion_top #(.FRAC_BITS(FRAC_BITS)) dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_e00   (req_mat.e00),
      .req_e01   (req_mat.e01),
      .req_e02   (req_mat.e02),
      .req_e10   (req_mat.e10),
      .req_e11   (req_mat.e11),
      .req_e12   (req_mat.e12),
      .req_e20   (req_mat.e20),
      .req_e21   (req_mat.e21),
      .req_e22   (req_mat.e22),
      .rsp_valid (rsp_valid),
      .rsp_q_w   (rsp_quat.w),
      .rsp_q_x   (rsp_quat.x),
      .rsp_q_y   (rsp_quat.y),
      .rsp_q_z   (rsp_quat.z)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // floor of the square root, one result bit at a time
   function automatic longint unsigned floor_sqrt(longint unsigned v);
      longint unsigned root;
      longint unsigned trial;
      root = 0;
      for (int b = 20; b >= 0; b--) begin
         trial = root | (longint'(1) << b);
         if (trial * trial <= v) root = trial;
      end
      return root;
   endfunction

   function automatic longint half_root_mag(longint diag_sum);
      longint unsigned r;
      if (diag_sum <= 0) return 0;
      r = floor_sqrt(longint'(diag_sum) << (FRAC_BITS - 2));
      if (r > UNIT) r = longint'(UNIT);
      return longint'(r);
   endfunction

   function automatic logic signed [XYZ_W-1:0] signed_mag(longint mag, longint diff);
      longint v;
      v = (diff < 0) ? -mag : mag;
      return v[XYZ_W-1:0];
   endfunction

   function automatic quat_type matrix_to_quat(matrix_type m);
      longint   a00, a01, a02, a10, a11, a12, a20, a21, a22;
      longint   w_sum, x_sum, y_sum, z_sum;
      quat_type q;
      a00 = m.e00; a01 = m.e01; a02 = m.e02;
      a10 = m.e10; a11 = m.e11; a12 = m.e12;
      a20 = m.e20; a21 = m.e21; a22 = m.e22;
      w_sum = UNIT + a00 + a11 + a22;
      x_sum = UNIT + a00 - a11 - a22;
      y_sum = UNIT - a00 + a11 - a22;
      z_sum = UNIT - a00 - a11 + a22;
      q.w = W_W'(half_root_mag(w_sum));
      q.x = signed_mag(half_root_mag(x_sum), a21 - a12);
      q.y = signed_mag(half_root_mag(y_sum), a02 - a20);
      q.z = signed_mag(half_root_mag(z_sum), a10 - a01);
      return q;
   endfunction

   function automatic logic signed [IN_W-1:0] to_q14(real r);
      return IN_W'($rtoi(r * UNIT));
   endfunction

   // a rotation from a random quaternion, its diagonal at times nudged by up to two LSB; zeroed parts give exact ties
   function automatic matrix_type random_rotation();
      real        qw, qx, qy, qz, n;
      matrix_type m;
      qw = real'(int'($urandom_range(20000)) - 10000);
      qx = real'(int'($urandom_range(20000)) - 10000);
      qy = real'(int'($urandom_range(20000)) - 10000);
      qz = real'(int'($urandom_range(20000)) - 10000);
      if ($urandom_range(7) == 0) qw = 0.0;
      if ($urandom_range(7) == 0) qx = 0.0;
      if ($urandom_range(7) == 0) qy = 0.0;
      if ($urandom_range(7) == 0) qz = 0.0;
      if (qw == 0.0 && qx == 0.0 && qy == 0.0 && qz == 0.0) qw = 1.0;
      n = $sqrt(qw * qw + qx * qx + qy * qy + qz * qz);
      qw = qw / n; qx = qx / n; qy = qy / n; qz = qz / n;
      m.e00 = to_q14(1.0 - 2.0 * (qy * qy + qz * qz));
      m.e01 = to_q14(2.0 * (qx * qy - qw * qz));
      m.e02 = to_q14(2.0 * (qx * qz + qw * qy));
      m.e10 = to_q14(2.0 * (qx * qy + qw * qz));
      m.e11 = to_q14(1.0 - 2.0 * (qx * qx + qz * qz));
      m.e12 = to_q14(2.0 * (qy * qz - qw * qx));
      m.e20 = to_q14(2.0 * (qx * qz - qw * qy));
      m.e21 = to_q14(2.0 * (qy * qz + qw * qx));
      m.e22 = to_q14(1.0 - 2.0 * (qx * qx + qy * qy));
      if ($urandom_range(3) == 0) begin
         m.e00 = m.e00 + IN_W'(int'($urandom_range(4)) - 2);
         m.e11 = m.e11 + IN_W'(int'($urandom_range(4)) - 2);
         m.e22 = m.e22 + IN_W'(int'($urandom_range(4)) - 2);
      end
      return m;
   endfunction

   function automatic matrix_type random_matrix();
      matrix_type m;
      int         pick;
      pick = $urandom_range(9);
      if (pick < 6) begin
         m = random_rotation();
      end else if (pick < 8) begin
         m.e00 = IN_W'(int'($urandom_range(40000)) - 20000);
         m.e01 = IN_W'(int'($urandom_range(40000)) - 20000);
         m.e02 = IN_W'(int'($urandom_range(40000)) - 20000);
         m.e10 = IN_W'(int'($urandom_range(40000)) - 20000);
         m.e11 = IN_W'(int'($urandom_range(40000)) - 20000);
         m.e12 = IN_W'(int'($urandom_range(40000)) - 20000);
         m.e20 = IN_W'(int'($urandom_range(40000)) - 20000);
         m.e21 = IN_W'(int'($urandom_range(40000)) - 20000);
         m.e22 = IN_W'(int'($urandom_range(40000)) - 20000);
      end else begin
         m = {$urandom(), $urandom(), $urandom(), $urandom(), 16'($urandom())};
      end
      return m;
   endfunction

   task automatic add_row(input int e00, e01, e02, e10, e11, e12, e20, e21, e22,
                          input bit fixed, input int w, x, y, z);
      stim_row_type row;
      row.mat = {16'(e00), 16'(e01), 16'(e02), 16'(e10), 16'(e11), 16'(e12),
                 16'(e20), 16'(e21), 16'(e22)};
      row.fixed = fixed;
      row.quat = {15'(w), 16'(x), 16'(y), 16'(z)};
      stim_table.push_back(row);
   endtask

   // busy only moves just after a rising edge, so its value at the falling
   // edge is the one the next rising edge sees
   task automatic send_matrix(input matrix_type m, input bit fixed, input quat_type given);
      while ($urandom_range(99) < idle_pct) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start   <= 1'b1;
      req_mat <= m;
      while (busy) @(negedge clock);
      @(posedge clock);
      quat_pending.push_back(fixed ? given : matrix_to_quat(m));
   endtask

   task automatic flag_field(input string field, input int exp_v, input int act_v);
      if (exp_v != act_v) begin
         $display("%0t: q_%s expected %0d, got %0d", $time, field, exp_v, act_v);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      quat_type exp_q;
      if (!reset && rsp_valid) begin
         if (quat_pending.size() == 0) begin
            $display("%0t: result beat with nothing outstanding", $time);
            mismatch_count++;
         end else begin
            exp_q = quat_pending.pop_front();
            flag_field("w", int'(exp_q.w), int'(rsp_quat.w));
            flag_field("x", int'(exp_q.x), int'(rsp_quat.x));
            flag_field("y", int'(exp_q.y), int'(rsp_quat.y));
            flag_field("z", int'(exp_q.z), int'(rsp_quat.z));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      int phase_idle [4];
      phase_idle = '{0, 84, 27, 0};
      reset   <= 1'b1;
      start   <= 1'b0;
      req_mat <= '0;

      add_row(16384, 0, 0, 0, 16384, 0, 0, 0, 16384, 1, 16384, 0, 0, 0);
      add_row(0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 8192, 8192, 8192, 8192);
      add_row(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767,
              1, 16384, 0, 0, 0);
      add_row(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768,
              0, 0, 0, 0, 0);
      add_row(16384, 0, 0, 0, -16384, 0, 0, 0, -16384, 1, 0, 16384, 0, 0);
      add_row(-16384, 0, 0, 0, 16384, 0, 0, 0, -16384, 1, 0, 0, 16384, 0);
      add_row(-16384, 0, 0, 0, -16384, 0, 0, 0, 16384, 1, 0, 0, 0, 16384);
      add_row(0, 0, 0, 0, 0, 32767, 0, -32768, 0, 1, 8192, -8192, 8192, 8192);
      add_row(0, 0, -32768, 0, 0, 0, 32767, 0, 0, 1, 8192, 8192, -8192, 8192);
      add_row(0, 32767, 0, -32768, 0, 0, 0, 0, 0, 1, 8192, 8192, 8192, -8192);
      add_row(0, 32767, 32767, 32767, 0, 32767, 32767, 32767, 0,
              1, 8192, 8192, 8192, 8192);
      add_row(0, 1, 0, 0, 0, 1, 1, 0, 0, 1, 8192, -8192, -8192, -8192);
      add_row(32767, 0, 0, 0, -32768, 0, 0, 0, -32768, 1, 0, 16384, 0, 0);
      add_row(0, -16384, 0, 16384, 0, 0, 0, 0, 16384, 0, 0, 0, 0, 0);
      add_row(32767, -32768, -32768, -32768, 32767, -32768, -32768, -32768, 32767,
              0, 0, 0, 0, 0);
      add_row(21845, -21846, 21845, -21846, 21845, -21846, 21845, -21846, 21845,
              0, 0, 0, 0, 0);
      add_row(-16383, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      add_row(11585, -11585, 0, 11585, 11585, 0, 0, 0, 16384, 0, 0, 0, 0, 0);

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (stim_table[i]) send_matrix(stim_table[i].mat, stim_table[i].fixed,
                                          stim_table[i].quat);

      for (int p = 0; p < 4; p++) begin
         idle_pct = phase_idle[p];
         for (int n = 0; n < PHASE_BEATS; n++) send_matrix(random_matrix(), 1'b0, '0);
         if (p == 0) begin
            // hold off until the pipeline has emptied
            @(negedge clock);
            start <= 1'b0;
            while (quat_pending.size() != 0) @(posedge clock);
         end
      end

      @(negedge clock);
      start <= 1'b0;
      while (quat_pending.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
